>>> src/ude_pkg.sv
// ----------------------------------------------------------------------------
// ude_pkg
// Shared types, character codes and formatting helpers for the UTF-8 decode
// and C-string escape block.
// ----------------------------------------------------------------------------
package ude_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_BSLASH = 7'h5C;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_HEX_LO = 7'h57;   // 'a' minus ten
    localparam logic [6:0] CH_U_LC   = 7'h75;
    localparam logic [6:0] CH_U_UC   = 7'h55;
    localparam logic [6:0] CH_N      = 7'h6E;
    localparam logic [6:0] CH_R      = 7'h72;
    localparam logic [6:0] CH_F      = 7'h66;
    localparam logic [6:0] CH_A      = 7'h61;
    localparam logic [6:0] CH_T      = 7'h74;

    localparam logic [7:0] B_QUOTE  = 8'h22;
    localparam logic [7:0] B_BSLASH = 8'h5C;
    localparam logic [7:0] B_LF     = 8'h0A;
    localparam logic [7:0] B_CR     = 8'h0D;
    localparam logic [7:0] B_FF     = 8'h0C;
    localparam logic [7:0] B_BEL    = 8'h07;
    localparam logic [7:0] B_TAB    = 8'h09;

    // how a code unit is spelled out
    typedef enum logic [2:0] {
        CL_PRINT,
        CL_OCT,
        CL_U4,
        CL_U8,
        CL_ESC
    } t_cls;

    // one classified input item, at most four output units
    typedef struct packed {
        logic        open_q;
        logic        a_vld;
        t_cls        a_cls;
        logic [30:0] a_val;
        logic        b_vld;
        t_cls        b_cls;
        logic [7:0]  b_val;
        logic        close_q;
        logic        closing;
    } t_job;

    function automatic t_cls classify(input logic [30:0] c);
        t_cls r;
        if (c inside {[31'h20:31'h7E]}) begin
            r = CL_PRINT;
        end else if (c <= 31'h7F) begin
            r = CL_OCT;
        end else if (c <= 31'hFFFF) begin
            r = CL_U4;
        end else begin
            r = CL_U8;
        end
        return r;
    endfunction

endpackage

>>> src/ude_front.sv
// ----------------------------------------------------------------------------
// ude_front
// Accepts source bytes, runs the relaxed UTF-8 decoder state and turns each
// byte that yields output into a job of quote, code and escape units for the expander.
// ----------------------------------------------------------------------------
module ude_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_string,
    input  logic          i_full,
    output logic          o_push,
    output ude_pkg::t_job o_job
);
    import ude_pkg::*;

    logic [30:0] r_partial, n_partial;
    logic [7:0]  r_lead, n_lead;
    logic [2:0]  r_len, n_len;
    logic [2:0]  r_ct, n_ct;
    logic        r_pend, n_pend;
    logic        r_open, n_open;
    logic        r_stop, n_stop;
    logic        r_wrap;

    logic        accept;
    logic        is_cont;
    logic        closing;
    logic [2:0]  ct_inc;
    logic [2:0]  sh_k;
    logic [30:0] cont_bits;
    logic [30:0] partial_upd;
    t_job        job;

    assign accept = i_in_valid & ~i_full;

    // continuation payload placed at its full-length position
    always_comb begin
        case (sh_k)
            3'd0:    cont_bits = {25'b0, i_in_byte[5:0]};
            3'd1:    cont_bits = {19'b0, i_in_byte[5:0], 6'b0};
            3'd2:    cont_bits = {13'b0, i_in_byte[5:0], 12'b0};
            3'd3:    cont_bits = {7'b0, i_in_byte[5:0], 18'b0};
            3'd4:    cont_bits = {1'b0, i_in_byte[5:0], 24'b0};
            3'd5:    cont_bits = {i_in_byte[0], 30'b0};
            default: cont_bits = '0;
        endcase
    end

    assign ct_inc      = r_ct + 3'd1;
    assign sh_k        = r_len - 3'd1 - ct_inc;
    assign partial_upd = (ct_inc < r_len) ? (r_partial | cont_bits) : r_partial;
    assign is_cont     = r_pend && (i_in_byte != 8'h00) && (i_in_byte[7:6] == 2'b10);

    always_comb begin
        n_partial = r_partial;
        n_lead    = r_lead;
        n_len     = r_len;
        n_ct      = r_ct;
        n_pend    = r_pend;
        n_open    = r_open;
        n_stop    = r_stop;
        closing   = 1'b0;
        job       = '0;
        job.a_cls = CL_PRINT;
        job.b_cls = CL_PRINT;

        if (r_stop) begin
            if (i_end_of_string) begin
                n_stop = 1'b0;
            end
        end else begin
            job.open_q = ~r_open & r_wrap;
            n_open     = 1'b1;
            if (is_cont) begin
                n_partial = partial_upd;
                n_ct      = ct_inc;
                if (({1'b0, ct_inc} + 4'd1 >= {1'b0, r_len}) || i_end_of_string) begin
                    job.a_vld = 1'b1;
                    job.a_val = partial_upd;
                    n_pend    = 1'b0;
                    n_ct      = 3'd0;
                end
            end else begin
                if (r_pend) begin
                    job.a_vld = 1'b1;
                    job.a_val = (r_ct == 3'd0) ? {23'b0, r_lead} : r_partial;
                    n_pend    = 1'b0;
                    n_ct      = 3'd0;
                end
                if (i_in_byte == 8'h00) begin
                    closing = 1'b1;
                    if (!i_end_of_string) begin
                        n_stop = 1'b1;
                    end
                end else begin
                    job.b_vld = 1'b1;
                    job.b_val = i_in_byte;
                    job.b_cls = classify({23'b0, i_in_byte});
                    case (i_in_byte)
                        B_QUOTE: begin
                            job.b_cls = CL_ESC;
                            job.b_val = {1'b0, CH_QUOTE};
                        end
                        B_BSLASH: begin
                            job.b_cls = CL_ESC;
                            job.b_val = {1'b0, CH_BSLASH};
                        end
                        B_LF: begin
                            job.b_cls = CL_ESC;
                            job.b_val = {1'b0, CH_N};
                        end
                        B_CR: begin
                            job.b_cls = CL_ESC;
                            job.b_val = {1'b0, CH_R};
                        end
                        B_FF: begin
                            job.b_cls = CL_ESC;
                            job.b_val = {1'b0, CH_F};
                        end
                        B_BEL: begin
                            job.b_cls = CL_ESC;
                            job.b_val = {1'b0, CH_A};
                        end
                        B_TAB: begin
                            job.b_cls = CL_ESC;
                            job.b_val = {1'b0, CH_T};
                        end
                        default: begin
                            if (i_in_byte inside {[8'hC0:8'hFD]}) begin
                                n_pend = 1'b1;
                                n_lead = i_in_byte;
                                n_ct   = 3'd0;
                                if (i_in_byte inside {[8'hC0:8'hDF]}) begin
                                    n_len     = 3'd2;
                                    n_partial = {20'b0, i_in_byte[4:0], 6'b0};
                                end else if (i_in_byte inside {[8'hE0:8'hEF]}) begin
                                    n_len     = 3'd3;
                                    n_partial = {15'b0, i_in_byte[3:0], 12'b0};
                                end else if (i_in_byte inside {[8'hF0:8'hF7]}) begin
                                    n_len     = 3'd4;
                                    n_partial = {10'b0, i_in_byte[2:0], 18'b0};
                                end else if (i_in_byte inside {[8'hF8:8'hFB]}) begin
                                    n_len     = 3'd5;
                                    n_partial = {5'b0, i_in_byte[1:0], 24'b0};
                                end else begin
                                    n_len     = 3'd6;
                                    n_partial = {i_in_byte[0], 30'b0};
                                end
                                // a lead byte stays pending unless the string ends here
                                if (i_end_of_string) begin
                                    n_pend = 1'b0;
                                end else begin
                                    job.b_vld = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            if (i_end_of_string) begin
                closing = 1'b1;
            end
            if (closing) begin
                job.close_q = r_wrap;
                job.closing = 1'b1;
                n_open      = 1'b0;
            end
        end
        job.a_cls = classify(job.a_val);
    end

    assign o_job  = job;
    assign o_push = accept & (job.open_q | job.a_vld | job.b_vld | job.close_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_lead    <= '0;
            r_len     <= '0;
            r_ct      <= '0;
            r_pend    <= 1'b0;
            r_open    <= 1'b0;
            r_stop    <= 1'b0;
            r_wrap    <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_wrap <= i_cfg_wr_data;
            end
            if (accept) begin
                r_partial <= n_partial;
                r_lead    <= n_lead;
                r_len     <= n_len;
                r_ct      <= n_ct;
                r_pend    <= n_pend;
                r_open    <= n_open;
                r_stop    <= n_stop;
            end
        end
    end

endmodule

>>> src/ude_queue.sv
// ----------------------------------------------------------------------------
// ude_queue
// Small job queue between the decoder front and the character expander.
// ----------------------------------------------------------------------------
module ude_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ude_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ude_pkg::t_job o_job
);
    import ude_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/ude_back.sv
// ----------------------------------------------------------------------------
// ude_back
// Expands the job at the queue head into escaped characters, one per cycle
// while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module ude_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ude_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [6:0]    o_out_char,
    output logic          o_last_of_run,
    output logic          o_string_done
);
    import ude_pkg::*;

    typedef enum logic [1:0] {
        U_OPEN,
        U_CODE_A,
        U_CODE_B,
        U_CLOSE
    } t_unit;

    t_unit       r_unit;
    logic [3:0]  r_k;
    logic        r_valid;
    logic [6:0]  r_char;
    logic        r_last;
    logic        r_done;

    logic [3:0]  pres;
    logic [1:0]  eff;
    logic        later_any;
    t_cls        cls;
    logic [30:0] val;
    logic [3:0]  unit_len;
    logic        unit_end;
    logic        job_last;
    logic        advance;
    logic [6:0]  ch;
    logic [2:0]  ni;
    logic [31:0] word;
    logic [3:0]  nib;
    logic [6:0]  hex_ch;

    assign pres = {i_job.close_q, i_job.b_vld, i_job.a_vld, i_job.open_q};

    // first unit present at or after the current position
    always_comb begin
        eff = U_CLOSE;
        for (int i = 3; i >= 0; i--) begin
            if (pres[i] && (2'(i) >= r_unit)) begin
                eff = 2'(i);
            end
        end
        later_any = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (pres[i] && (2'(i) > eff)) begin
                later_any = 1'b1;
            end
        end
    end

    always_comb begin
        if (eff == U_CODE_B) begin
            cls = i_job.b_cls;
            val = {23'b0, i_job.b_val};
        end else begin
            cls = i_job.a_cls;
            val = i_job.a_val;
        end
    end

    assign word   = {1'b0, val};
    assign ni     = 3'(((cls == CL_U8) ? 4'd9 : 4'd5) - r_k);
    assign nib    = word[{ni, 2'b00} +: 4];
    assign hex_ch = (nib < 4'd10) ? (CH_ZERO + {3'b0, nib}) : (CH_HEX_LO + {3'b0, nib});

    always_comb begin
        unit_len = 4'd1;
        ch       = CH_QUOTE;
        if (eff == U_CODE_A || eff == U_CODE_B) begin
            case (cls)
                CL_PRINT: begin
                    unit_len = 4'd1;
                    ch       = val[6:0];
                end
                CL_OCT: begin
                    unit_len = 4'd4;
                    case (r_k)
                        4'd0:    ch = CH_BSLASH;
                        4'd1:    ch = CH_ZERO + {4'b0, val[8:6]};
                        4'd2:    ch = CH_ZERO + {4'b0, val[5:3]};
                        default: ch = CH_ZERO + {4'b0, val[2:0]};
                    endcase
                end
                CL_ESC: begin
                    unit_len = 4'd2;
                    ch       = (r_k == 4'd0) ? CH_BSLASH : val[6:0];
                end
                CL_U4, CL_U8: begin
                    unit_len = (cls == CL_U8) ? 4'd10 : 4'd6;
                    case (r_k)
                        4'd0:    ch = CH_BSLASH;
                        4'd1:    ch = (cls == CL_U8) ? CH_U_UC : CH_U_LC;
                        default: ch = hex_ch;
                    endcase
                end
                default: begin
                    unit_len = 4'd1;
                    ch       = val[6:0];
                end
            endcase
        end
    end

    assign unit_end = (r_k == unit_len - 4'd1);
    assign job_last = unit_end & ~later_any;
    assign advance  = i_q_valid & (~r_valid | ~i_out_stall);
    assign o_pop    = advance & job_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit  <= U_OPEN;
            r_k     <= '0;
            r_valid <= 1'b0;
            r_char  <= '0;
            r_last  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_char  <= ch;
                r_last  <= job_last;
                r_done  <= job_last & i_job.closing;
                if (job_last) begin
                    r_unit <= U_OPEN;
                    r_k    <= '0;
                end else if (unit_end) begin
                    r_unit <= t_unit'(eff + 2'd1);
                    r_k    <= '0;
                end else begin
                    r_k <= r_k + 4'd1;
                end
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_char    = r_char;
    assign o_last_of_run = r_last;
    assign o_string_done = r_done;

endmodule

>>> src/utf8_decode_and_escape.sv
// ----------------------------------------------------------------------------
// utf8_decode_and_escape
// Relaxed UTF-8 decoder that writes C-style escaped ASCII, optionally quoted.
// A byte's job is registered in the job queue, then its characters are
// registered in the output register. One byte is accepted per cycle while the
// job queue has room; the expander writes one character per cycle unless stalled.
// Reset: synchronous active low; clears decoder state, queue and output
// register, wrap_quotes returns to 1.
// ----------------------------------------------------------------------------
module utf8_decode_and_escape (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_out_char,
    output logic       o_last_of_run,
    output logic       o_string_done
);
    import ude_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_head;

    assign o_in_stall = q_full;

    ude_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_full          (q_full),
        .o_push          (push),
        .o_job           (job_in)
    );

    ude_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (job_head)
    );

    ude_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (job_head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run),
        .o_string_done (o_string_done)
    );

endmodule

>>> verif/utf8_decode_and_escape_test.sv
// ----------------------------------------------------------------------------
// utf8_decode_and_escape_test
// Self-checking bench for the UTF-8 decode and C-string escape block. A short
// table of bytes walks the escapes, raw byte cases, sequence extremes and
// zero-byte closing. Several phases of random strings follow, each phase under
// its own quote setting. Each accepted byte is run through a local decoder
// model, and every output beat is compared with the oldest predicted char.
// ----------------------------------------------------------------------------
module utf8_decode_and_escape_test;
    import ude_pkg::*;

    localparam int LIMIT       = 1_500_000;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 20;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 50;
    localparam int DIR_ROWS    = 28;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       done;
    } t_esc_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_end_of_string;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [6:0] o_out_char;
    logic       o_last_of_run;
    logic       o_string_done;

    // decoder model state
    logic [30:0] dec_code;
    logic [7:0]  dec_lead;
    logic [2:0]  dec_len;
    logic [2:0]  dec_taken;
    bit          dec_busy;
    bit          str_open;
    bit          nul_skip;
    bit          wrap_on;

    t_esc_char   run_q[$];
    t_esc_char   pending_chars[$];
    logic [7:0]  src_byte[$];
    logic        src_eos[$];
    int          gen_count;
    bit          gen_skip;

    bit          calm;
    int          stall_run = 0;
    int          cycles = 0;
    int          errors = 0;
    int          n_bytes = 0;
    int          n_silent = 0;
    int          n_chars = 0;
    int          n_strings = 0;

    utf8_decode_and_escape dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_last_of_run   (o_last_of_run),
        .o_string_done   (o_string_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    function automatic void put_ch(input logic [6:0] c);
        t_esc_char beat;
        beat.ch   = c;
        beat.last = 1'b0;
        beat.done = 1'b0;
        run_q.push_back(beat);
    endfunction

    function automatic logic [6:0] hex_digit(input logic [3:0] d);
        return (d < 4'd10) ? CH_ZERO + {3'b0, d} : CH_HEX_LO + {3'b0, d};
    endfunction

    function automatic void put_code(input logic [30:0] c);
        logic [31:0] v;
        v = {1'b0, c};
        if (c >= 31'h20 && c <= 31'h7E) begin
            put_ch(c[6:0]);
        end else if (c <= 31'h7F) begin
            put_ch(CH_BSLASH);
            put_ch(CH_ZERO + {4'b0, c[8:6]});
            put_ch(CH_ZERO + {4'b0, c[5:3]});
            put_ch(CH_ZERO + {4'b0, c[2:0]});
        end else if (c <= 31'hFFFF) begin
            put_ch(CH_BSLASH);
            put_ch(CH_U_LC);
            for (int sh = 12; sh >= 0; sh -= 4) put_ch(hex_digit(v[sh +: 4]));
        end else begin
            put_ch(CH_BSLASH);
            put_ch(CH_U_UC);
            for (int sh = 28; sh >= 0; sh -= 4) put_ch(hex_digit(v[sh +: 4]));
        end
    endfunction

    function automatic void flush_seq();
        if (dec_busy) begin
            if (dec_taken == 3'd0) put_code({23'b0, dec_lead});
            else put_code(dec_code);
            dec_busy  = 1'b0;
            dec_taken = 3'd0;
        end
    endfunction

    function automatic void put_esc(input logic [6:0] c);
        put_ch(CH_BSLASH);
        put_ch(c);
    endfunction

    function automatic void fresh_byte(input logic [7:0] b);
        int          len;
        logic [7:0]  mask;
        logic [31:0] v;
        len  = 0;
        mask = 8'h00;
        case (b)
            B_QUOTE:  put_esc(CH_QUOTE);
            B_BSLASH: put_esc(CH_BSLASH);
            B_LF:     put_esc(CH_N);
            B_CR:     put_esc(CH_R);
            B_FF:     put_esc(CH_F);
            B_BEL:    put_esc(CH_A);
            B_TAB:    put_esc(CH_T);
            default: begin
                if ((b & 8'hE0) == 8'hC0) begin
                    len = 2; mask = 8'h1F;
                end else if ((b & 8'hF0) == 8'hE0) begin
                    len = 3; mask = 8'h0F;
                end else if ((b & 8'hF8) == 8'hF0) begin
                    len = 4; mask = 8'h07;
                end else if ((b & 8'hFC) == 8'hF8) begin
                    len = 5; mask = 8'h03;
                end else if ((b & 8'hFE) == 8'hFC) begin
                    len = 6; mask = 8'h01;
                end
                if (len == 0) begin
                    put_code({23'b0, b});
                end else begin
                    v         = {24'b0, b & mask} << (6 * (len - 1));
                    dec_busy  = 1'b1;
                    dec_lead  = b;
                    dec_len   = len[2:0];
                    dec_taken = 3'd0;
                    dec_code  = v[30:0];
                end
            end
        endcase
    endfunction

    // fills run_q with the chars one accepted byte produces
    function automatic void decode_byte(input logic [7:0] b, input logic e);
        bit          closing;
        logic [31:0] v;
        t_esc_char   tail;
        closing = 1'b0;
        run_q.delete();
        if (nul_skip) begin
            if (e) nul_skip = 1'b0;
            return;
        end
        if (!str_open) begin
            str_open = 1'b1;
            if (wrap_on) put_ch(CH_QUOTE);
        end
        if (dec_busy && b != 8'h00 && b[7:6] == 2'b10) begin
            dec_taken = dec_taken + 3'd1;
            if (dec_taken < dec_len) begin
                v        = {26'b0, b[5:0]} << (6 * (int'(dec_len) - 1 - int'(dec_taken)));
                dec_code = dec_code | v[30:0];
            end
            if (int'(dec_taken) + 1 >= int'(dec_len)) flush_seq();
        end else begin
            flush_seq();
            if (b == 8'h00) begin
                closing = 1'b1;
                if (!e) nul_skip = 1'b1;
            end else begin
                fresh_byte(b);
            end
        end
        if (e) closing = 1'b1;
        if (closing) begin
            flush_seq();
            if (wrap_on) put_ch(CH_QUOTE);
            str_open = 1'b0;
        end
        if (run_q.size() > 0) begin
            tail      = run_q.pop_back();
            tail.last = 1'b1;
            tail.done = closing;
            run_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // directed table; an empty text means the model supplies the chars
    function automatic void dir_row(input int i, output logic [7:0] b, output logic e,
                                    output string txt);
        e   = 1'b0;
        txt = "";
        case (i)
            0:  begin b = 8'h41; txt = "\"A"; end
            1:  begin b = B_QUOTE;  txt = "\\\""; end
            2:  begin b = B_BSLASH; txt = "\\\\"; end
            3:  begin b = B_LF;     txt = "\\n"; end
            4:  begin b = B_CR;     txt = "\\r"; end
            5:  begin b = B_FF;     txt = "\\f"; end
            6:  begin b = B_BEL;    txt = "\\a"; end
            7:  begin b = B_TAB;    txt = "\\t"; end
            8:  begin b = 8'h7F; txt = "\\177"; end
            9:  begin b = 8'h80; txt = "\\u0080"; end
            10: begin b = 8'hFE; txt = "\\u00fe"; end
            11: begin b = 8'hFF; txt = "\\u00ff"; end
            // lead byte followed by plain ascii
            12: b = 8'hC3;
            13: b = 8'h41;
            // overlong zero
            14: b = 8'hC0;
            15: begin b = 8'h80; txt = "\\000"; end
            // six-byte sequence with every payload bit set
            16: b = 8'hFD;
            17, 18, 19, 20: b = 8'hBF;
            21: begin b = 8'hBF; txt = "\\U7fffffff"; end
            // five-byte sequence cut short, string ends on the next byte
            22: b = 8'hF8;
            23: b = 8'h88;
            24: begin b = 8'h41; e = 1'b1; end
            // zero byte closes, rest of the string is dropped
            25: begin b = 8'h00; txt = "\"\""; end
            26: begin b = 8'h42; e = 1'b1; end
            27: begin b = 8'h00; e = 1'b1; txt = "\"\""; end
            default: b = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] lead_for(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            4:       return {5'b11110, r[2:0]};
            5:       return {6'b111110, r[1:0]};
            default: return {7'b1111110, r[0]};
        endcase
    endfunction

    function automatic void add_src(input logic [7:0] b);
        src_byte.push_back(b);
        src_eos.push_back(1'b0);
        if (!gen_skip) gen_count++;
        if (b == 8'h00) gen_skip = 1'b1;
    endfunction

    function automatic logic [7:0] esc_byte();
        case ($urandom_range(0, 6))
            0:       return B_QUOTE;
            1:       return B_BSLASH;
            2:       return B_LF;
            3:       return B_CR;
            4:       return B_FF;
            5:       return B_BEL;
            default: return B_TAB;
        endcase
    endfunction

    // random strings, mostly well-formed sequences with noise mixed in
    function automatic void build_phase(input int want);
        int nch;
        int len;
        int r;
        gen_count = 0;
        while (gen_count < want) begin
            nch      = $urandom_range(1, 8);
            gen_skip = 1'b0;
            for (int c = 0; c < nch; c++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    len = $urandom_range(1, 6);
                    if (len == 1) begin
                        add_src(8'($urandom_range(1, 127)));
                    end else begin
                        add_src(lead_for(len));
                        repeat (len - 1) add_src(cont_byte());
                    end
                end else if (r < 58) begin
                    add_src(esc_byte());
                end else if (r < 70) begin
                    // truncated sequence
                    len = $urandom_range(2, 6);
                    add_src(lead_for(len));
                    repeat ($urandom_range(0, len - 2)) add_src(cont_byte());
                end else if (r < 84) begin
                    add_src(8'($urandom_range(1, 255)));
                end else if (r < 91) begin
                    if ($urandom_range(0, 2) == 0) add_src(8'($urandom_range(254, 255)));
                    else add_src(cont_byte());
                end else if (r < 95) begin
                    add_src(8'h00);
                end else begin
                    add_src(8'($urandom_range(0, 255)));
                end
            end
            src_eos[src_eos.size() - 1] = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic e, input string txt);
        int        gap;
        bit        done_f;
        byte       tc;
        t_esc_char beat;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_in_byte  <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_end_of_string <= e;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        n_bytes++;
        decode_byte(b, e);
        if (run_q.size() == 0) n_silent++;
        if (txt.len() > 0) begin
            // typed text stands in for the model chars, flags stay the model's
            done_f = (run_q.size() > 0) ? run_q[run_q.size() - 1].done : 1'b0;
            run_q.delete();
            for (int k = 0; k < txt.len(); k++) begin
                tc        = txt[k];
                beat.ch   = tc[6:0];
                beat.last = (k == txt.len() - 1);
                beat.done = beat.last && done_f;
                run_q.push_back(beat);
            end
        end
        while (run_q.size() > 0) pending_chars.push_back(run_q.pop_front());
    endtask

    task automatic drain();
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_wrap(input bit w);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        wrap_on = w;
    endtask

    initial begin : main
        logic [7:0] b;
        logic       e;
        string      txt;
        bit         w;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= 1'b0;
        i_in_valid      <= 1'b0;
        i_in_byte       <= 8'h00;
        i_end_of_string <= 1'b0;
        calm      = 1'b0;
        dec_code  = '0;
        dec_lead  = '0;
        dec_len   = '0;
        dec_taken = '0;
        dec_busy  = 1'b0;
        str_open  = 1'b0;
        nul_skip  = 1'b0;
        wrap_on   = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_wrap(1'b1);

        for (int i = 0; i < DIR_ROWS; i++) begin
            dir_row(i, b, e, txt);
            send_byte(b, e, txt);
        end
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0, 2:    w = 1'b0;
                1, 4:    w = 1'b1;
                default: w = $urandom_range(0, 1);
            endcase
            write_wrap(w);
            calm = (ph == 2);
            build_phase(PHASE_ITEMS);
            while (src_byte.size() > 0) send_byte(src_byte.pop_front(), src_eos.pop_front(), "");
            i_in_valid <= 1'b0;
        end
        calm = 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        $display("covered %0d source bytes (%0d directed, %0d with no output) in %0d phases",
                 n_bytes, DIR_ROWS, n_silent, PHASES + 1);
        $display("checked %0d escaped chars, %0d strings closed, %0d mismatches",
                 n_chars, n_strings, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // output side: random stall and beat checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_esc_char want;
        t_esc_char got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got = {o_out_char, o_last_of_run, o_string_done};
            n_chars++;
            if (o_string_done === 1'b1) n_strings++;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, got char %h last %b done %b",
                         $time, got.ch, got.last, got.done);
            end else begin
                want = pending_chars.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: beat mismatch, expected char %h last %b done %b, got char %h last %b done %b",
                             $time, want.ch, want.last, want.done,
                             got.ch, got.last, got.done);
                end
            end
        end
        if (stall_run > 0) begin
            i_out_stall <= 1'b1;
            stall_run   <= stall_run - 1;
        end else if (calm || $urandom_range(0, 99) < 70) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= 1'b1;
            stall_run   <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                      : $urandom_range(8, 30);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("%0t: timeout with %0d chars still expected", $time, pending_chars.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // leftover expectations are caught by the drain loop timing out
endmodule

>>> filelist.f
src/ude_pkg.sv
src/ude_front.sv
src/ude_queue.sv
src/ude_back.sv
src/utf8_decode_and_escape.sv
verif/utf8_decode_and_escape_test.sv
